// ----- rtl/pfht_pkg.sv -----
// Package for the point-in-figures hit test.
// Holds the operation codes, the controller states and the fixed port widths.
// No dependencies.
package pfht_pkg;

    localparam int IN_W   = 32;  // width of every coordinate port
    localparam int QNUM_W = 32;  // query number width
    localparam int FIG_W  = 6;   // figure number width

    typedef enum logic [1:0] {
        OP_ADD_RECT   = 2'd0,
        OP_ADD_CIRCLE = 2'd1,
        OP_QUERY      = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

// ----- rtl/point_in_figures_hit_test.sv -----
// Point-in-figures hit test: a figure table in one synchronous memory and a
// pipelined walker that tests a query point against every stored figure.
// Depends on pfht_pkg.
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------------
//  command   start, busy             operation, first_x, first_y, second_x,
//                                    second_y, radius
//  result    result_strobe           query_number, figure_number, contained, last
//
// Add and clear commands complete while busy stays low.
// A query holds busy while the walker reads one table entry per cycle from the
// memory port and the circle test pipeline adds its depth before the final beat,
// which shows in the same cycle that busy falls. Hit beats come out as the walk
// proceeds, at most one per cycle. The results are registered and shown for one
// cycle each; the receiver cannot stall them. Reset clears the figure count, the
// query number (to one) and all control state; the table contents need no reset.
module point_in_figures_hit_test #(
    parameter int MAX_FIGURES = 32,
    parameter int COORD_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  pfht_pkg::op_t                operation,
    input  logic signed [pfht_pkg::IN_W-1:0] first_x,
    input  logic signed [pfht_pkg::IN_W-1:0] first_y,
    input  logic signed [pfht_pkg::IN_W-1:0] second_x,
    input  logic signed [pfht_pkg::IN_W-1:0] second_y,
    input  logic signed [pfht_pkg::IN_W-1:0] radius,
    output logic                         result_strobe,
    output logic [pfht_pkg::QNUM_W-1:0]  query_number,
    output logic [pfht_pkg::FIG_W-1:0]   figure_number,
    output logic                         contained,
    output logic                         last
);
    import pfht_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int CNT_W  = $clog2(MAX_FIGURES + 1);
    localparam int ADDR_W = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
    localparam int WORD_W = 4 * CW + 1;
    localparam int MAG_W  = 31;       // magnitudes below 2^31 take part in the square test
    localparam int SQ_W   = 2 * MAG_W;

    // Table memory: {is_circle, y_high, y_low, x_high, x_low}.
    logic [WORD_W-1:0] mem [MAX_FIGURES];

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  issue_reg;
    logic [QNUM_W-1:0] qnum_reg;
    logic signed [CW-1:0] px_reg, py_reg;

    logic accept;
    logic issue;
    logic finish;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // Incoming coordinates, taken from their low COORD_WIDTH bits.
    logic signed [CW-1:0] ax, ay, bx, by, rad;
    logic [WORD_W-1:0]    wr_word;

    assign accept = start && !busy;
    assign ax  = first_x[CW-1:0];
    assign ay  = first_y[CW-1:0];
    assign bx  = second_x[CW-1:0];
    assign by  = second_y[CW-1:0];
    assign rad = radius[CW-1:0];

    always_comb
    begin
        if (operation == OP_ADD_CIRCLE)
        begin
            wr_word = {1'b1, {CW{1'b0}}, ay, rad, ax};
        end
        else
        begin
            wr_word = {1'b0,
                       (ay < by) ? by : ay, (ay < by) ? ay : by,
                       (ax < bx) ? bx : ax, (ax < bx) ? ax : bx};
        end
    end

    // Controller: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation == OP_QUERY)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (issue_reg >= count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg && !v4_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller: outputs.
    always_comb
    begin
        busy   = 1'b1;
        issue  = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:   busy = 1'b0;
            ST_WALK:   issue = (issue_reg < count_reg);
            ST_DRAIN:  ;
            ST_FINISH: finish = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            issue_reg <= '0;
            qnum_reg  <= QNUM_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                unique case (operation) inside
                    OP_ADD_RECT, OP_ADD_CIRCLE:
                    begin
                        if (count_reg < CNT_W'(MAX_FIGURES))
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                    OP_QUERY: issue_reg <= '0;
                    OP_CLEAR: count_reg <= '0;
                    default:  ;
                endcase
            end
            if (issue)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
            if (finish)
            begin
                qnum_reg <= qnum_reg + QNUM_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_QUERY)
        begin
            px_reg <= ax;
            py_reg <= ay;
        end
    end

    // Memory write port (adds) and registered read port (walker).
    logic [WORD_W-1:0] rd_q_reg;

    always_ff @(posedge clk)
    begin
        if (accept && (operation == OP_ADD_RECT || operation == OP_ADD_CIRCLE)
            && count_reg < CNT_W'(MAX_FIGURES))
        begin
            mem[count_reg[ADDR_W-1:0]] <= wr_word;
        end
        if (issue)
        begin
            rd_q_reg <= mem[issue_reg[ADDR_W-1:0]];
        end
    end

    // Pipeline valid bits; control state, so reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 1: unpack the entry, rectangle compares and coordinate differences.
    logic [ADDR_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic                 e_circ;
    logic signed [CW-1:0] e_xl, e_xh, e_yl, e_yh;
    logic                 s1_rect;
    logic signed [CW:0]   s1_dx, s1_dy;

    assign {e_circ, e_yh, e_yl, e_xh, e_xl} = rd_q_reg;
    assign s1_rect = (px_reg > e_xl) && (px_reg < e_xh) && (py_reg > e_yl) && (py_reg < e_yh);
    assign s1_dx   = (CW+1)'(px_reg) - (CW+1)'(e_xl);
    assign s1_dy   = (CW+1)'(py_reg) - (CW+1)'(e_yl);

    logic                 circ2_reg, rect2_reg, rpos2_reg;
    logic signed [CW:0]   dx2_reg, dy2_reg;
    logic signed [CW-1:0] r2_reg;

    always_ff @(posedge clk)
    begin
        idx2_reg  <= idx1_reg;
        circ2_reg <= e_circ;
        rect2_reg <= s1_rect;
        rpos2_reg <= !e_xh[CW-1] && (e_xh != '0);
        dx2_reg   <= s1_dx;
        dy2_reg   <= s1_dy;
        r2_reg    <= e_xh;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            idx1_reg <= issue_reg[ADDR_W-1:0];
        end
    end

    // Stage 2: magnitudes, flagging radii <= 0 and those too large to ever fit the circle.
    logic [CW:0] s2_mx, s2_my;
    logic [32:0] s2_mx_ext, s2_my_ext, s2_r_ext;

    assign s2_mx     = dx2_reg[CW] ? $unsigned(-dx2_reg) : $unsigned(dx2_reg);
    assign s2_my     = dy2_reg[CW] ? $unsigned(-dy2_reg) : $unsigned(dy2_reg);
    assign s2_mx_ext = 33'(s2_mx);
    assign s2_my_ext = 33'(s2_my);
    assign s2_r_ext  = 33'($unsigned(r2_reg));

    logic             circ3_reg, rect3_reg, ok3_reg;
    logic [MAG_W-1:0] mx3_reg, my3_reg, r3_reg;

    always_ff @(posedge clk)
    begin
        idx3_reg  <= idx2_reg;
        circ3_reg <= circ2_reg;
        rect3_reg <= rect2_reg;
        ok3_reg   <= rpos2_reg && (s2_mx_ext[32:31] == 2'b00) && (s2_my_ext[32:31] == 2'b00);
        mx3_reg   <= s2_mx_ext[MAG_W-1:0];
        my3_reg   <= s2_my_ext[MAG_W-1:0];
        r3_reg    <= s2_r_ext[MAG_W-1:0];
    end

    // Stage 3: the three squares.
    logic            circ4_reg, rect4_reg, ok4_reg;
    logic [SQ_W-1:0] sqx4_reg, sqy4_reg, sqr4_reg;

    always_ff @(posedge clk)
    begin
        idx4_reg  <= idx3_reg;
        circ4_reg <= circ3_reg;
        rect4_reg <= rect3_reg;
        ok4_reg   <= ok3_reg;
        sqx4_reg  <= SQ_W'(mx3_reg) * SQ_W'(mx3_reg);
        sqy4_reg  <= SQ_W'(my3_reg) * SQ_W'(my3_reg);
        sqr4_reg  <= SQ_W'(r3_reg) * SQ_W'(r3_reg);
    end

    // Stage 4: final decision for this figure.
    logic             s4_circ_hit, s4_hit;
    logic [FIG_W-1:0] s4_fig;

    assign s4_circ_hit = ok4_reg &&
        (({1'b0, sqx4_reg} + {1'b0, sqy4_reg}) < {1'b0, sqr4_reg});
    assign s4_hit = v4_reg && (circ4_reg ? s4_circ_hit : rect4_reg);
    assign s4_fig = FIG_W'(CNT_W'(idx4_reg) + CNT_W'(1));

    // The latest hit is held back one beat so that the final beat can carry last.
    logic             pend_valid_reg;
    logic [FIG_W-1:0] pend_fig_reg;
    logic             res_strobe_reg;
    logic [QNUM_W-1:0] res_qnum_reg;
    logic [FIG_W-1:0] res_fig_reg;
    logic             res_cont_reg, res_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            res_strobe_reg <= (s4_hit && pend_valid_reg) || finish;
            if (s4_hit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (finish)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_hit)
        begin
            pend_fig_reg <= s4_fig;
        end
        res_qnum_reg <= qnum_reg;
        res_fig_reg  <= pend_valid_reg ? pend_fig_reg : '0;
        res_cont_reg <= pend_valid_reg;
        res_last_reg <= finish;
    end

    assign result_strobe = res_strobe_reg;
    assign query_number  = res_qnum_reg;
    assign figure_number = res_fig_reg;
    assign contained     = res_cont_reg;
    assign last          = res_last_reg;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for point_in_figures_hit_test: a command driver and a
// result monitor around a behavioral hit-test predictor of the figure table.
// Depends on pfht_pkg and the block's RTL.
module tb;
    import pfht_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int ONE         = 65536;          // 1.0 in Q16.16
    localparam int NEAR_SPAN   = 40 * ONE;
    localparam int COORD_MAX   = 2147483647;
    localparam int COORD_MIN   = -2147483647 - 1;
    localparam int RANDOM_CMDS = 320;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        op_t                op;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] rad;
        bit                 settle_first;   // hold until all hit reports are in
    } cmd_t;

    typedef struct {
        logic [QNUM_W-1:0] qnum;
        logic [FIG_W-1:0]  fig;
        logic              hit;
        logic              final_beat;
    } hit_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    op_t operation = OP_ADD_RECT;
    logic signed [IN_W-1:0] first_x = '0;
    logic signed [IN_W-1:0] first_y = '0;
    logic signed [IN_W-1:0] second_x = '0;
    logic signed [IN_W-1:0] second_y = '0;
    logic signed [IN_W-1:0] radius = '0;
    logic busy;
    logic result_strobe;
    logic [QNUM_W-1:0] query_number;
    logic [FIG_W-1:0] figure_number;
    logic contained;
    logic last;

    cmd_t        cmd_backlog[$];
    hit_report_t hit_reports_due[$];
    cmd_t        cmd_on_bus;
    hit_report_t seen_want;
    int          cmds_taken = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          launch;
    bit          quiet;

    // Predictor copy of the figure table.
    bit                fig_circle[TABLE_DEPTH];
    longint            fig_xlo[TABLE_DEPTH];
    longint            fig_xhi[TABLE_DEPTH];
    longint            fig_ylo[TABLE_DEPTH];
    longint            fig_yhi[TABLE_DEPTH];
    int                fig_count = 0;
    logic [QNUM_W-1:0] next_query_no = 1;

    point_in_figures_hit_test u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .first_x       (first_x),
        .first_y       (first_y),
        .second_x      (second_x),
        .second_y      (second_y),
        .radius        (radius),
        .result_strobe (result_strobe),
        .query_number  (query_number),
        .figure_number (figure_number),
        .contained     (contained),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit point_inside(int idx, longint px, longint py);
        longint            r;
        longint            dx;
        longint            dy;
        longint unsigned   ax;
        longint unsigned   ay;
        if (!fig_circle[idx])
            return px > fig_xlo[idx] && px < fig_xhi[idx] &&
                   py > fig_ylo[idx] && py < fig_yhi[idx];
        r  = fig_xhi[idx];
        dx = px - fig_xlo[idx];
        dy = py - fig_ylo[idx];
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        // Beyond 2^31 on either axis the squared distance exceeds any radius squared.
        if (r <= 0 || ax >= 64'd2147483648 || ay >= 64'd2147483648)
            return 1'b0;
        return ax * ax + ay * ay < longint'(r) * longint'(r);
    endfunction

    task automatic hit_test_predict(input cmd_t c);
        int          hits[$];
        hit_report_t rep;
        longint      ax;
        longint      ay;
        longint      bx;
        longint      by;
        ax = longint'(c.fx);
        ay = longint'(c.fy);
        bx = longint'(c.sx);
        by = longint'(c.sy);
        case (c.op) inside
            OP_CLEAR: fig_count = 0;
            OP_ADD_RECT, OP_ADD_CIRCLE:
            begin
                if (fig_count < TABLE_DEPTH)
                begin
                    if (c.op == OP_ADD_RECT)
                    begin
                        fig_circle[fig_count] = 1'b0;
                        fig_xlo[fig_count] = (ax < bx) ? ax : bx;
                        fig_xhi[fig_count] = (ax < bx) ? bx : ax;
                        fig_ylo[fig_count] = (ay < by) ? ay : by;
                        fig_yhi[fig_count] = (ay < by) ? by : ay;
                    end
                    else
                    begin
                        fig_circle[fig_count] = 1'b1;
                        fig_xlo[fig_count] = ax;
                        fig_ylo[fig_count] = ay;
                        fig_xhi[fig_count] = longint'(c.rad);
                        fig_yhi[fig_count] = 0;
                    end
                    fig_count++;
                end
            end
            default:
            begin
                for (int i = 0; i < fig_count; i++)
                    if (point_inside(i, ax, ay))
                        hits = {hits, i + 1};
                rep.qnum = next_query_no;
                if (hits.size() == 0)
                begin
                    rep.fig = '0;
                    rep.hit = 1'b0;
                    rep.final_beat = 1'b1;
                    hit_reports_due = {hit_reports_due, rep};
                end
                foreach (hits[k])
                begin
                    rep.fig = hits[k][FIG_W-1:0];
                    rep.hit = 1'b1;
                    rep.final_beat = (k == hits.size() - 1);
                    hit_reports_due = {hit_reports_due, rep};
                end
                next_query_no = next_query_no + 1;
            end
        endcase
    endtask

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic push_cmd(input op_t op, input int fx, input int fy, input int sx,
                            input int sy, input int rad, input bit settle);
        cmd_t c;
        c.op = op;
        c.fx = fx;
        c.fy = fy;
        c.sx = sx;
        c.sy = sy;
        c.rad = rad;
        c.settle_first = settle;
        cmd_backlog = {cmd_backlog, c};
    endtask

    // Mostly coordinates in a small box so figures overlap and hits are common.
    function automatic int pick_coord();
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        return int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
    endfunction

    function automatic int pick_radius();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            return $urandom_range(1, 30 * ONE);
        if (sel == 8)
            return -int'($urandom_range(0, 30 * ONE));
        return $urandom;
    endfunction

    // Command driver: one beat is accepted at an edge with start high and busy low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            operation <= OP_ADD_RECT;
            first_x   <= '0;
            first_y   <= '0;
            second_x  <= '0;
            second_y  <= '0;
            radius    <= '0;
        end
        else
        begin
            launch = start;
            if (start && !busy)
            begin
                hit_test_predict(cmd_on_bus);
                cmds_taken++;
                launch = 1'b0;
            end
            if (!launch && cmd_backlog.size() != 0)
            begin
                quiet = cmds_taken >= 120 && cmds_taken < 200;
                if (!(cmd_backlog[0].settle_first && hit_reports_due.size() != 0) &&
                    (quiet || $urandom_range(0, 99) >= 15))
                begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    operation <= cmd_on_bus.op;
                    first_x   <= cmd_on_bus.fx;
                    first_y   <= cmd_on_bus.fy;
                    second_x  <= cmd_on_bus.sx;
                    second_y  <= cmd_on_bus.sy;
                    radius    <= cmd_on_bus.rad;
                    launch = 1'b1;
                end
            end
            start <= launch;
        end
    end

    // Result monitor: each strobed beat is checked against the oldest expected report.
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (hit_reports_due.size() == 0)
                flag_mismatch($sformatf("unexpected beat query %0d figure %0d hit %0b last %0b",
                                        query_number, figure_number, contained, last));
            else
            begin
                seen_want = hit_reports_due.pop_front();
                if (query_number !== seen_want.qnum || figure_number !== seen_want.fig ||
                    contained !== seen_want.hit || last !== seen_want.final_beat)
                    flag_mismatch($sformatf(
                        "got query %0d figure %0d hit %0b last %0b, want %0d %0d %0b %0b",
                        query_number, figure_number, contained, last, seen_want.qnum,
                        seen_want.fig, seen_want.hit, seen_want.final_beat));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int made;
        int n_add;
        int n_q;
        int seq_no;
        bit settle;
        made = 0;
        seq_no = 0;

        // Directed: empty table, edges, degenerate figures, boundary distances, extremes.
        push_cmd(OP_QUERY, 0, 0, 0, 0, 0, 1'b0);
        push_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 1'b0);
        push_cmd(OP_ADD_RECT, 10 * ONE, 10 * ONE, -10 * ONE, -10 * ONE, COORD_MIN, 1'b0);
        push_cmd(OP_ADD_RECT, 5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE, 0, 1'b0);
        push_cmd(OP_ADD_CIRCLE, 0, 0, COORD_MAX, COORD_MIN, 5 * ONE, 1'b0);
        push_cmd(OP_ADD_CIRCLE, 0, 0, 0, 0, -5 * ONE, 1'b0);
        push_cmd(OP_ADD_CIRCLE, 0, 0, 0, 0, 0, 1'b0);
        push_cmd(OP_QUERY, 0, 0, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        push_cmd(OP_QUERY, 10 * ONE, 0, 0, 0, 0, 1'b0);
        push_cmd(OP_QUERY, 3 * ONE, 4 * ONE, 0, 0, 0, 1'b0);
        push_cmd(OP_QUERY, 3 * ONE, 4 * ONE - 1, 0, 0, 0, 1'b0);
        push_cmd(OP_ADD_RECT, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 1'b0);
        push_cmd(OP_QUERY, COORD_MIN, 0, 0, 0, 0, 1'b0);
        push_cmd(OP_QUERY, COORD_MAX - 1, COORD_MAX - 1, 0, 0, 0, 1'b0);
        push_cmd(OP_ADD_CIRCLE, COORD_MAX, COORD_MIN, 0, 0, COORD_MAX, 1'b0);
        push_cmd(OP_QUERY, 0, 0, 0, 0, 0, 1'b0);
        push_cmd(OP_QUERY, COORD_MAX - 1000, COORD_MIN + 1000, 0, 0, 0, 1'b0);
        push_cmd(OP_ADD_CIRCLE, 0, 0, 0, 0, COORD_MIN, 1'b0);
        push_cmd(OP_QUERY, 1, -1, 0, 0, 0, 1'b0);
        push_cmd(OP_CLEAR, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
        push_cmd(OP_QUERY, 0, 0, 0, 0, 0, 1'b0);

        // Random: usually a clear, a run of adds, then queries; the first run overfills the table.
        while (made < RANDOM_CMDS)
        begin
            settle = (seq_no == 1) || ($urandom_range(0, 7) == 0);
            if (seq_no == 0 || $urandom_range(0, 3) != 0)
            begin
                push_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, settle);
                settle = 1'b0;
                made++;
            end
            if (seq_no == 0)
                n_add = 35;
            else if ($urandom_range(0, 9) == 0)
                n_add = $urandom_range(28, 36);
            else
                n_add = $urandom_range(0, 12);
            for (int k = 0; k < n_add; k++)
            begin
                if ($urandom_range(0, 1) == 0)
                    push_cmd(OP_ADD_RECT, pick_coord(), pick_coord(), pick_coord(),
                             pick_coord(), $urandom, settle);
                else
                    push_cmd(OP_ADD_CIRCLE, pick_coord(), pick_coord(), $urandom, $urandom,
                             pick_radius(), settle);
                settle = 1'b0;
                if (k < TABLE_DEPTH)
                    made++;
            end
            n_q = $urandom_range(1, 6);
            for (int k = 0; k < n_q; k++)
            begin
                push_cmd(OP_QUERY, pick_coord(), pick_coord(), $urandom, $urandom, $urandom,
                         settle);
                settle = 1'b0;
                made++;
            end
            // Noise: any operation with full-range fields.
            for (int k = $urandom_range(0, 2); k > 0; k--)
            begin
                push_cmd(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                         $urandom, 1'b0);
                made++;
            end
            seq_no++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
        while (hit_reports_due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
